>>> hdl/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// types and constants shared by the gradient color map
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int CHAN_BITS  = 8;
  localparam int NUM_CHANS  = 3;
  localparam int POS_BITS   = 16;
  localparam int STOP_BITS  = POS_BITS + NUM_CHANS * CHAN_BITS;
  localparam int COUNT_BITS = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MIN_STOPS  = 2;

  // register map
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_FIRST = 3'd1;

  typedef logic [CHAN_BITS-1:0] chan_t;
  // index 2 red, 1 green, 0 blue
  typedef logic [NUM_CHANS-1:0][CHAN_BITS-1:0] rgb_t;

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    rgb_t                color;
  } stop_t;

  localparam logic [COUNT_BITS-1:0] STOP_COUNT_RESET = 3'd2;
  localparam logic [STOP_BITS-1:0]  STOP_RESET       = '0;
  localparam logic [STOP_BITS-1:0]  STOP_ONE_RESET   = '1;

endpackage

>>> hdl/gradient_color_map_core.sv
// ----------------------------------------------------------------------------
// gradient_color_map_core
// path from the input transfer to out_valid: stage 1, stage 2, divider, multiply stage, output stage
// throughput: one pixel per cycle while the output is not stalled, set by the one-bit-per-stage weight divider
// a stall on the output freezes the whole pipeline, nothing is lost or repeated
// reset (rst, synchronous): pipeline empties, stop_count = 2, stop 1 all ones,
// every other stop zero
// ----------------------------------------------------------------------------
module gradient_color_map_core #(
  parameter int MAX_STOPS        = 6,
  parameter int SAMPLE_BITS      = 16,
  parameter int WEIGHT_FRAC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [gcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gcm_pkg::STOP_BITS-1:0]    cfg_data,
  // sample input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  // pixel output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gcm_pkg::CHAN_BITS-1:0]    red,
  output logic [gcm_pkg::CHAN_BITS-1:0]    green,
  output logic [gcm_pkg::CHAN_BITS-1:0]    blue
);
  import gcm_pkg::*;

  localparam int WF = WEIGHT_FRAC_BITS;
  // width that holds both a sample and a stop position
  localparam int XW = (SAMPLE_BITS > POS_BITS) ? SAMPLE_BITS : POS_BITS;
  localparam int IW = $clog2(MAX_STOPS);
  // (rc - lc) * w product width
  localparam int PW = CHAN_BITS + 1 + WF + 1;
  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_STOPS);
  localparam logic [COUNT_BITS-1:0] MIN_COUNT = COUNT_BITS'(MIN_STOPS);

  // --------------------------------------------------------------------------
  // configuration registers, only the stops that can ever be in use are kept
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] stop_count;
  stop_t                 stops [MAX_STOPS];
  logic [CFG_INDEX_BITS-1:0] stop_sel;

  assign stop_sel = cfg_index - REG_STOP_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= STOP_COUNT_RESET;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stops[i] <= (i == 1) ? stop_t'(STOP_ONE_RESET) : stop_t'(STOP_RESET);
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_STOP_COUNT) begin
        stop_count <= cfg_data[COUNT_BITS-1:0];
      end else if (32'(stop_sel) < MAX_STOPS) begin
        // index past the kept stops is dropped here as well
        stops[stop_sel[IW-1:0]] <= stop_t'(cfg_data);
      end
    end
  end

  function automatic logic signed [XW-1:0] pos_ext(stop_t st);
    return XW'($signed(st.pos));
  endfunction

  // --------------------------------------------------------------------------
  // pipeline control: every stage moves together whenever the output slot
  // is empty or its pixel is taken in this cycle
  // --------------------------------------------------------------------------
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // --------------------------------------------------------------------------
  // stage 1: sample register
  // --------------------------------------------------------------------------
  logic                          s1_vld;
  logic signed [SAMPLE_BITS-1:0] s1_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (advance) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sample <= sample;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: stop search and neighbor select
  // first stop in use whose position is above the sample; below the first
  // stop or past the last one the weight is forced to zero on one end stop
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] n;
  logic [COUNT_BITS-1:0] end_idx;
  logic [COUNT_BITS-1:0] left_idx;
  logic [COUNT_BITS-1:0] right_idx;
  logic                  found;
  logic                  at_end;
  logic signed [XW-1:0]  s_ext;
  logic signed [XW-1:0]  left_pos;
  logic signed [XW-1:0]  right_pos;
  logic signed [XW:0]    num_full;
  logic signed [XW:0]    den_full;
  logic [XW-1:0]         num2;
  logic [XW-1:0]         den2;

  always_comb begin
    priority if (stop_count < MIN_COUNT) begin
      cnt = MIN_COUNT;
    end else if (stop_count > MAX_COUNT) begin
      cnt = MAX_COUNT;
    end else begin
      cnt = stop_count;
    end
  end

  assign s_ext = XW'(s1_sample);

  always_comb begin
    found = 1'b0;
    n     = cnt;
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (!found && (COUNT_BITS'(i) < cnt) && (pos_ext(stops[i]) > s_ext)) begin
        found = 1'b1;
        n     = COUNT_BITS'(i);
      end
    end
  end

  assign at_end    = !found || (n == '0);
  assign end_idx   = (n == '0) ? '0 : cnt - 1'b1;
  assign left_idx  = at_end ? end_idx : n - 1'b1;
  assign right_idx = at_end ? end_idx : n;
  assign left_pos  = pos_ext(stops[left_idx[IW-1:0]]);
  assign right_pos = pos_ext(stops[right_idx[IW-1:0]]);
  assign num_full  = (XW+1)'(s_ext) - (XW+1)'(left_pos);
  assign den_full  = (XW+1)'(right_pos) - (XW+1)'(left_pos);
  // inside the ramp both differences are non-negative and below 2^XW
  assign num2      = at_end ? '0 : num_full[XW-1:0];
  assign den2      = at_end ? XW'(1) : den_full[XW-1:0];

  // --------------------------------------------------------------------------
  // weight divider: entry 0 is stage 2, each further entry resolves one
  // quotient bit of num * 2^WF / den by restoring division (num < den)
  // --------------------------------------------------------------------------
  logic          div_vld [WF+1];
  logic [XW-1:0] div_rem [WF+1];
  logic [XW-1:0] div_den [WF+1];
  logic [WF-1:0] div_q   [WF+1];
  rgb_t          div_lc  [WF+1];
  rgb_t          div_rc  [WF+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else if (advance) begin
      div_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      div_rem[0] <= num2;
      div_den[0] <= den2;
      div_q[0]   <= '0;
      div_lc[0]  <= stops[left_idx[IW-1:0]].color;
      div_rc[0]  <= stops[right_idx[IW-1:0]].color;
    end
  end

  for (genvar d = 1; d <= WF; d++) begin : g_div
    logic [XW:0] trial;
    logic [XW:0] diff;
    logic        fits;

    assign trial = {div_rem[d-1], 1'b0};
    assign fits  = trial >= {1'b0, div_den[d-1]};
    assign diff  = trial - {1'b0, div_den[d-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[d] <= 1'b0;
      end else if (advance) begin
        div_vld[d] <= div_vld[d-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        div_rem[d] <= fits ? diff[XW-1:0] : trial[XW-1:0];
        div_den[d] <= div_den[d-1];
        div_q[d]   <= {div_q[d-1][WF-2:0], fits};
        div_lc[d]  <= div_lc[d-1];
        div_rc[d]  <= div_rc[d-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // multiply stage: (right - left) * weight per channel
  // --------------------------------------------------------------------------
  logic                 mul_vld;
  logic signed [PW-1:0] mul_prod [NUM_CHANS];
  rgb_t                 mul_lc;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else if (advance) begin
      mul_vld <= div_vld[WF];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mul_lc <= div_lc[WF];
      for (int c = 0; c < NUM_CHANS; c++) begin
        mul_prod[c] <= PW'($signed({1'b0, div_rc[WF][c]}) - $signed({1'b0, div_lc[WF][c]}))
                       * $signed({1'b0, div_q[WF]});
      end
    end
  end

  // --------------------------------------------------------------------------
  // output stage: left + floor(product >> WF), clamped to 0..255, held until the transfer
  // --------------------------------------------------------------------------
  rgb_t pix_next;

  always_comb begin
    logic signed [CHAN_BITS+2:0] sum;
    for (int c = 0; c < NUM_CHANS; c++) begin
      // arithmetic shift of the product is the floor
      sum = (CHAN_BITS+3)'($signed({1'b0, mul_lc[c]}))
          + (CHAN_BITS+3)'($signed(mul_prod[c][PW-1:WF]));
      if (sum < 0) begin
        pix_next[c] = '0;
      end else if (sum > (CHAN_BITS+3)'(255)) begin
        pix_next[c] = '1;
      end else begin
        pix_next[c] = sum[CHAN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red   <= pix_next[2];
      green <= pix_next[1];
      blue  <= pix_next[0];
    end
  end

endmodule
